/* sv/sbff_pkg.sv */
// ============================================================================
// sbff_pkg
// Shared constants, codes, character-class helpers and a saturating
// increment for the body fingerprint filter.
// ============================================================================
package sbff_pkg;

  // Width of the saturating statistics counters.
  localparam int COUNT_WIDTH = 16;
  // Width of the threshold registers.
  localparam int THRESH_WIDTH = 16;
  // Common width used when a counter is compared against a threshold.
  localparam int CMP_WIDTH = (COUNT_WIDTH > THRESH_WIDTH) ? COUNT_WIDTH : THRESH_WIDTH;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FILTER_MODE    = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_LINE_FEEDS = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_BLANKS     = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_DELIMITERS = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_LENGTH     = 3'd4;

  // Filter codes, used both for the mode register and the reported selection.
  localparam logic [1:0] FILTER_WHITESPACE = 2'd0;
  localparam logic [1:0] FILTER_PUNCT      = 2'd1;
  localparam logic [1:0] FILTER_GRAPHIC    = 2'd2;
  localparam logic [1:0] FILTER_NONE       = 2'd3;

  // Reset values of the threshold registers.
  localparam logic [THRESH_WIDTH-1:0] RST_MIN_LINE_FEEDS = 16'd2;
  localparam logic [THRESH_WIDTH-1:0] RST_MIN_BLANKS     = 16'd20;
  localparam logic [THRESH_WIDTH-1:0] RST_MIN_DELIMITERS = 16'd3;
  localparam logic [THRESH_WIDTH-1:0] RST_MIN_LENGTH     = 16'd8;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  function automatic logic is_cntrl(input logic [7:0] c);
    return (c < 8'd32) || (c == CH_DEL);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_print(input logic [7:0] c);
    return (c >= 8'd32) && (c <= 8'd126);
  endfunction

  function automatic logic is_graph(input logic [7:0] c);
    return (c >= 8'd33) && (c <= 8'd126);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // Special glyphs counted as delimiters: < > ( ) | @ * ' ! ? ,
  function automatic logic is_glyph(input logic [7:0] c);
    return (c == 8'h3C) || (c == 8'h3E) || (c == 8'h28) || (c == 8'h29) ||
           (c == 8'h7C) || (c == 8'h40) || (c == 8'h2A) || (c == 8'h27) ||
           (c == 8'h21) || (c == 8'h3F) || (c == 8'h2C);
  endfunction

  // HTML entity characters: % & # ; =
  function automatic logic is_html(input logic [7:0] c);
    return (c == 8'h25) || (c == 8'h26) || (c == 8'h23) || (c == 8'h3B) ||
           (c == CH_EQUAL);
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v,
                                                     input logic en);
    if (en && (v != {COUNT_WIDTH{1'b1}})) begin
      return v + COUNT_WIDTH'(1);
    end
    return v;
  endfunction

endpackage

/* sv/spam_body_fingerprint_filter.sv */
// ============================================================================
// spam_body_fingerprint_filter
// Byte filter and statistics front end for a body fingerprint hash.
// ============================================================================
// Use of the block
//   Body bytes arrive on the s_ side, one byte per word, with s_tlast set on
//   the final byte of a body. The filter selected by the filter_mode register
//   decides which bytes are kept; each kept byte, under the whitespace filter
//   only a byte that is not graphic, leaves on the m_ side with byte_valid
//   set, ready for a downstream MD5 unit. The final byte of a body always
//   produces a word, with m_tlast set and the filter chosen by the statistics
//   thresholds in selected_filter. Other bytes produce no word at all.
//   From acceptance to the result word a byte sits in the input register,
//   then the filter and counter logic feeds the output register. One byte
//   can be accepted in every cycle while the output is not stalled; the rate
//   is set only by the combinational path through the character tests and the counters.
//   When the receiver stalls, the output register holds its word and the
//   input register still takes one more byte; after that s_tready falls.
//   Bytes that produce no word still drain while the output is stalled.
//   Reset (rst, synchronous) empties both registers, clears the body state
//   and loads the threshold reset values. Configuration writes are taken at
//   once through cfg_we and should be made while no body is in flight.
// ============================================================================
module spam_body_fingerprint_filter (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [sbff_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [sbff_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  // Body bytes in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  // Kept bytes and end-of-body report out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // end_of_body
  output logic [2:0]  m_tuser    // [0] byte_valid, [2:1] selected_filter
);

  localparam int CW = sbff_pkg::COUNT_WIDTH;
  localparam int TW = sbff_pkg::THRESH_WIDTH;
  localparam int MW = sbff_pkg::CMP_WIDTH;

  // Configuration registers
  logic [1:0]    filter_mode;
  logic [TW-1:0] min_line_feeds;
  logic [TW-1:0] min_blanks;
  logic [TW-1:0] min_delimiters;
  logic [TW-1:0] min_length;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Body state
  logic [7:0]    previous_kept;
  logic          previous_valid;
  logic [7:0]    previous_raw;
  logic [CW-1:0] line_feed_count;
  logic [CW-1:0] blank_count;
  logic [CW-1:0] delimiter_count;
  logic [CW-1:0] length_count;

  // Output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_emit;
  logic       out_end;
  logic [1:0] out_sel;

  // Combinational results for the byte in the input register
  logic          emit;
  logic [7:0]    emit_byte;
  logic          keep;
  logic [1:0]    sel;
  logic [CW-1:0] line_feed_count_next;
  logic [CW-1:0] blank_count_next;
  logic [CW-1:0] delimiter_count_next;
  logic [CW-1:0] length_count_next;
  logic          has_result;
  logic          advance;
  logic [7:0]    mapped;
  logic          same_prev;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode    <= sbff_pkg::FILTER_WHITESPACE;
      min_line_feeds <= sbff_pkg::RST_MIN_LINE_FEEDS;
      min_blanks     <= sbff_pkg::RST_MIN_BLANKS;
      min_delimiters <= sbff_pkg::RST_MIN_DELIMITERS;
      min_length     <= sbff_pkg::RST_MIN_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        sbff_pkg::REG_FILTER_MODE:    filter_mode    <= cfg_data[1:0];
        sbff_pkg::REG_MIN_LINE_FEEDS: min_line_feeds <= cfg_data[TW-1:0];
        sbff_pkg::REG_MIN_BLANKS:     min_blanks     <= cfg_data[TW-1:0];
        sbff_pkg::REG_MIN_DELIMITERS: min_delimiters <= cfg_data[TW-1:0];
        sbff_pkg::REG_MIN_LENGTH:     min_length     <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. The byte in the input register moves on when the output
  // register can take its word, or when it produces no word at all.
  // ---------------------------------------------------------------------------
  assign has_result = emit || in_last;
  assign advance    = in_valid && (!has_result || !out_valid || m_tready);
  assign s_tready   = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Statistics. Counts include the current byte, so the selection on the
  // final byte sees it too.
  // ---------------------------------------------------------------------------
  always_comb begin
    line_feed_count_next = sbff_pkg::sat_inc(line_feed_count, in_byte == sbff_pkg::CH_LF);
    blank_count_next     = sbff_pkg::sat_inc(blank_count,
                             (in_byte == sbff_pkg::CH_SPACE) || (in_byte == sbff_pkg::CH_TAB));
    delimiter_count_next = sbff_pkg::sat_inc(delimiter_count,
                             ((in_byte == sbff_pkg::CH_SLASH) &&
                              (previous_raw == sbff_pkg::CH_COLON)) ||
                             sbff_pkg::is_glyph(in_byte));
    length_count_next    = sbff_pkg::sat_inc(length_count, 1'b1);

    if ((MW'(line_feed_count_next) >= MW'(min_line_feeds)) &&
        (MW'(blank_count_next) >= MW'(min_blanks))) begin
      sel = sbff_pkg::FILTER_WHITESPACE;
    end else if (MW'(delimiter_count_next) >= MW'(min_delimiters)) begin
      sel = sbff_pkg::FILTER_PUNCT;
    end else if (MW'(length_count_next) >= MW'(min_length)) begin
      sel = sbff_pkg::FILTER_GRAPHIC;
    end else begin
      sel = sbff_pkg::FILTER_NONE;
    end
  end

  // ---------------------------------------------------------------------------
  // Filtering. Only the punctuation filter rewrites a byte (underscore to
  // dot); the comparison with the previous kept byte uses the rewritten value.
  // ---------------------------------------------------------------------------
  assign mapped    = (in_byte == sbff_pkg::CH_UNDER) ? sbff_pkg::CH_DOT : in_byte;
  assign same_prev = previous_valid &&
                     (previous_kept == ((filter_mode == sbff_pkg::FILTER_PUNCT) ?
                                        mapped : in_byte));

  always_comb begin
    emit_byte = in_byte;
    keep      = 1'b0;
    emit      = 1'b0;
    case (filter_mode)
      sbff_pkg::FILTER_WHITESPACE: begin
        // Whitespace runs collapse, and a line feed after a kept CR goes.
        keep = !((previous_valid && (previous_kept == sbff_pkg::CH_CR) &&
                  (in_byte == sbff_pkg::CH_LF)) ||
                 (sbff_pkg::is_space(in_byte) && same_prev));
        emit = keep && !sbff_pkg::is_graph(in_byte);
      end
      sbff_pkg::FILTER_PUNCT: begin
        emit_byte = mapped;
        keep = !(sbff_pkg::is_cntrl(in_byte) || sbff_pkg::is_alnum(in_byte) ||
                 sbff_pkg::is_html(in_byte)) &&
               !(sbff_pkg::is_print(mapped) && same_prev);
        emit = keep;
      end
      sbff_pkg::FILTER_GRAPHIC: begin
        keep = !(sbff_pkg::is_cntrl(in_byte) || sbff_pkg::is_space(in_byte) ||
                 (in_byte == sbff_pkg::CH_EQUAL)) &&
               !(sbff_pkg::is_graph(in_byte) && same_prev);
        emit = keep;
      end
      default: begin
        // No filter active: nothing is kept, counting carries on.
        keep = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Body state. The final byte of a body clears everything.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_kept   <= '0;
      previous_valid  <= 1'b0;
      previous_raw    <= '0;
      line_feed_count <= '0;
      blank_count     <= '0;
      delimiter_count <= '0;
      length_count    <= '0;
    end else if (advance) begin
      if (in_last) begin
        previous_kept   <= '0;
        previous_valid  <= 1'b0;
        previous_raw    <= '0;
        line_feed_count <= '0;
        blank_count     <= '0;
        delimiter_count <= '0;
        length_count    <= '0;
      end else begin
        if (keep) begin
          previous_kept  <= emit_byte;
          previous_valid <= 1'b1;
        end
        previous_raw    <= in_byte;
        line_feed_count <= line_feed_count_next;
        blank_count     <= blank_count_next;
        delimiter_count <= delimiter_count_next;
        length_count    <= length_count_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && has_result) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_byte <= emit ? emit_byte : 8'd0;
      out_emit <= emit;
      out_end  <= in_last;
      out_sel  <= in_last ? sel : sbff_pkg::FILTER_WHITESPACE;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_end;
  assign m_tuser  = {out_sel, out_emit};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A word is only ever produced for a kept byte or the end of a body.
  a_word_has_cause: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] || m_tlast))
    else $error("result word with neither a kept byte nor end of body");

  // The selection field stays zero except on the final word of a body.
  a_sel_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser[2:1] == sbff_pkg::FILTER_WHITESPACE))
    else $error("selected_filter set on a word that is not the last");

  // After a body's final byte its length and delimiter counts and previous bytes are clear.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> ((length_count == '0) && !previous_valid &&
                              (delimiter_count == '0) && (previous_raw == '0)))
    else $error("body state not cleared after final byte");

  // Within a body the length counter never falls (it saturates).
  a_length_monotone: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_last) |=> (length_count >= $past(length_count)) &&
                              (length_count != '0))
    else $error("length counter wrapped or fell within a body");

  // An output word held under back-pressure keeps its byte and end flag.
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> (out_valid && $stable(out_byte) && $stable(out_end)))
    else $error("stalled result word changed");

endmodule

/* tb/spam_body_fingerprint_filter_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for spam_body_fingerprint_filter
// Feeds message body bytes through the stream input, with register settings
// changed between phases. A model of the three byte filters and the four
// saturating counters in this bench predicts output words (or a script row
// spells one out); each word leaving the block is checked field by field.
// ----------------------------------------------------------------------------
module spam_body_fingerprint_filter_test;

  // One output word of the block, in the order its fields are checked.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       end_of_body;
    logic [1:0] selected_filter;
  } body_word_t;

  // Rows of the directed script. A register write, a byte whose word comes
  // from the model, a byte that must produce no word, or a byte whose word is
  // written out in the row itself.
  typedef enum logic [1:0] {ROW_CFG, ROW_CHECKED, ROW_SILENT, ROW_TYPED} row_kind_t;

  typedef struct packed {
    row_kind_t                            kind;
    logic [sbff_pkg::CFG_INDEX_WIDTH-1:0] reg_index;
    logic [sbff_pkg::CFG_DATA_WIDTH-1:0]  reg_value;
    logic [7:0]                           data;
    logic                                 last;
    body_word_t                           word;
  } script_row_t;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 8;
  // Time to let bytes that make no word drain from the block.
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int STAGE_WORDS   = 180;
  localparam int PHASE_WORDS   = 45;

  // Register index past the end of the list; writes to it are ignored.
  localparam logic [sbff_pkg::CFG_INDEX_WIDTH-1:0] REG_BEYOND = 3'd7;
  localparam logic [sbff_pkg::CFG_DATA_WIDTH-1:0]  ALL_ONES   = 16'hFFFF;

  localparam string GLYPHS   = "<>()|@*'!?,";
  localparam string ENTITIES = "%&#;=";

  // Clock, reset and every input start from known values.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                 cfg_we    = 1'b0;
  logic [sbff_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [sbff_pkg::CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = '0;
  logic       s_tlast  = 1'b0;

  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [2:0] m_tuser;

  // Idling percentages for the sender and the receiver.
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;

  int mismatches  = 0;
  int cycle_count = 0;

  // Words still owed by the block, oldest first.
  body_word_t expected_words[$];

  // Bench copy of the registers, starting at their reset values.
  logic [1:0]                        mode_reg   = sbff_pkg::FILTER_WHITESPACE;
  logic [sbff_pkg::THRESH_WIDTH-1:0] lf_need    = sbff_pkg::RST_MIN_LINE_FEEDS;
  logic [sbff_pkg::THRESH_WIDTH-1:0] blank_need = sbff_pkg::RST_MIN_BLANKS;
  logic [sbff_pkg::THRESH_WIDTH-1:0] delim_need = sbff_pkg::RST_MIN_DELIMITERS;
  logic [sbff_pkg::THRESH_WIDTH-1:0] len_need   = sbff_pkg::RST_MIN_LENGTH;

  // Bench copy of the per-body state.
  logic [7:0]                       kept_byte  = '0;
  logic                             kept_valid = 1'b0;
  logic [7:0]                       raw_byte   = '0;
  logic [sbff_pkg::COUNT_WIDTH-1:0] lf_seen    = '0;
  logic [sbff_pkg::COUNT_WIDTH-1:0] blank_seen = '0;
  logic [sbff_pkg::COUNT_WIDTH-1:0] delim_seen = '0;
  logic [sbff_pkg::COUNT_WIDTH-1:0] len_seen   = '0;

  script_row_t script[$];

  spam_body_fingerprint_filter uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #CLK_HALF clk = ~clk;

  // Watchdog: a run that hangs on a handshake ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Character classes of the C locale; bytes 128 to 255 belong to none.
  // --------------------------------------------------------------------------
  function automatic logic ctl_char(input logic [7:0] c);
    return (c < 8'd32) || (c == sbff_pkg::CH_DEL);
  endfunction

  function automatic logic blank_class(input logic [7:0] c);
    return (c == sbff_pkg::CH_SPACE) || ((c >= sbff_pkg::CH_TAB) && (c <= sbff_pkg::CH_CR));
  endfunction

  function automatic logic printable(input logic [7:0] c);
    return (c >= 8'd32) && (c <= 8'd126);
  endfunction

  function automatic logic graphic(input logic [7:0] c);
    return (c >= 8'd33) && (c <= 8'd126);
  endfunction

  function automatic logic alnum_char(input logic [7:0] c);
    return ((c >= "0") && (c <= "9")) || ((c >= "A") && (c <= "Z")) ||
           ((c >= "a") && (c <= "z"));
  endfunction

  // The sets hold no NUL, so a zero byte never matches.
  function automatic logic in_chars(input string set, input logic [7:0] c);
    for (int i = 0; i < set.len(); i++) begin
      if (set[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [sbff_pkg::COUNT_WIDTH-1:0] bumped(
      input logic [sbff_pkg::COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic same_as_kept(input logic [7:0] c);
    return kept_valid && (kept_byte == c);
  endfunction

  // --------------------------------------------------------------------------
  // Filter and counter model. Takes one accepted byte, updates the bench
  // state and returns 1 with the word the block owes for it, or 0 when the
  // byte is neither sent nor final.
  // --------------------------------------------------------------------------
  function automatic logic predict_word(input logic [7:0] c, input logic last,
                                        output body_word_t w);
    logic       emit;
    logic [7:0] mapped;
    logic [1:0] sel;
    emit   = 1'b0;
    mapped = c;
    sel    = sbff_pkg::FILTER_WHITESPACE;

    if (c == sbff_pkg::CH_LF) lf_seen = bumped(lf_seen);
    if ((c == sbff_pkg::CH_SPACE) || (c == sbff_pkg::CH_TAB)) blank_seen = bumped(blank_seen);
    if (((c == sbff_pkg::CH_SLASH) && (raw_byte == sbff_pkg::CH_COLON)) ||
        in_chars(GLYPHS, c))
      delim_seen = bumped(delim_seen);
    len_seen = bumped(len_seen);
    raw_byte = c;

    case (mode_reg)
      sbff_pkg::FILTER_WHITESPACE: begin
        // Runs of one whitespace byte collapse, and LF after a kept CR goes.
        if (!((kept_valid && (kept_byte == sbff_pkg::CH_CR) && (c == sbff_pkg::CH_LF)) ||
              (blank_class(c) && same_as_kept(c)))) begin
          kept_byte  = c;
          kept_valid = 1'b1;
          emit       = !graphic(c);
        end
      end
      sbff_pkg::FILTER_PUNCT: begin
        if (!(ctl_char(c) || alnum_char(c) || in_chars(ENTITIES, c))) begin
          mapped = (c == sbff_pkg::CH_UNDER) ? sbff_pkg::CH_DOT : c;
          if (!(printable(mapped) && same_as_kept(mapped))) begin
            kept_byte  = mapped;
            kept_valid = 1'b1;
            emit       = 1'b1;
          end
        end
      end
      sbff_pkg::FILTER_GRAPHIC: begin
        if (!(ctl_char(c) || blank_class(c) || (c == sbff_pkg::CH_EQUAL))) begin
          if (!(graphic(c) && same_as_kept(c))) begin
            kept_byte  = c;
            kept_valid = 1'b1;
            emit       = 1'b1;
          end
        end
      end
      default: ;  // filter none: counting only
    endcase

    if (last) begin
      if ((lf_seen >= lf_need) && (blank_seen >= blank_need))
        sel = sbff_pkg::FILTER_WHITESPACE;
      else if (delim_seen >= delim_need) sel = sbff_pkg::FILTER_PUNCT;
      else if (len_seen >= len_need) sel = sbff_pkg::FILTER_GRAPHIC;
      else sel = sbff_pkg::FILTER_NONE;
      kept_byte  = '0;
      kept_valid = 1'b0;
      raw_byte   = '0;
      lf_seen    = '0;
      blank_seen = '0;
      delim_seen = '0;
      len_seen   = '0;
    end

    w.byte_valid      = emit;
    w.out_byte        = emit ? mapped : 8'h00;
    w.end_of_body     = last;
    w.selected_filter = last ? sel : sbff_pkg::FILTER_WHITESPACE;
    return emit || last;
  endfunction

  // --------------------------------------------------------------------------
  // Script row builders.
  // --------------------------------------------------------------------------
  function automatic script_row_t cfg_row(input logic [sbff_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                          input logic [sbff_pkg::CFG_DATA_WIDTH-1:0] val);
    script_row_t r;
    r           = '0;
    r.kind      = ROW_CFG;
    r.reg_index = idx;
    r.reg_value = val;
    return r;
  endfunction

  function automatic script_row_t byte_row(input row_kind_t kind, input logic [7:0] d,
                                           input logic l);
    script_row_t r;
    r      = '0;
    r.kind = kind;
    r.data = d;
    r.last = l;
    return r;
  endfunction

  function automatic script_row_t typed_row(input logic [7:0] d, input logic l,
                                            input logic bv, input logic [7:0] ob,
                                            input logic eob, input logic [1:0] sel);
    script_row_t r;
    r      = byte_row(ROW_TYPED, d, l);
    r.word = '{byte_valid: bv, out_byte: ob, end_of_body: eob, selected_filter: sel};
    return r;
  endfunction

  function automatic logic [sbff_pkg::CFG_DATA_WIDTH-1:0] pick_threshold();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return sbff_pkg::CFG_DATA_WIDTH'($urandom);
      default: return sbff_pkg::CFG_DATA_WIDTH'($urandom_range(0, 12));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Register writes. The strobe drops for a cycle between writes so that it
  // never takes two assignments in one step.
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [sbff_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [sbff_pkg::CFG_DATA_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sbff_pkg::REG_FILTER_MODE:    mode_reg   = val[1:0];
      sbff_pkg::REG_MIN_LINE_FEEDS: lf_need    = val;
      sbff_pkg::REG_MIN_BLANKS:     blank_need = val;
      sbff_pkg::REG_MIN_DELIMITERS: delim_need = val;
      sbff_pkg::REG_MIN_LENGTH:     len_need   = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [sbff_pkg::CFG_DATA_WIDTH-1:0] mode,
                               input logic [sbff_pkg::CFG_DATA_WIDTH-1:0] lf,
                               input logic [sbff_pkg::CFG_DATA_WIDTH-1:0] blanks,
                               input logic [sbff_pkg::CFG_DATA_WIDTH-1:0] delims,
                               input logic [sbff_pkg::CFG_DATA_WIDTH-1:0] len);
    write_reg(sbff_pkg::REG_FILTER_MODE, mode);
    write_reg(sbff_pkg::REG_MIN_LINE_FEEDS, lf);
    write_reg(sbff_pkg::REG_MIN_BLANKS, blanks);
    write_reg(sbff_pkg::REG_MIN_DELIMITERS, delims);
    write_reg(sbff_pkg::REG_MIN_LENGTH, len);
  endtask

  // Stop sending, wait for every owed word, then let any byte that makes no
  // word clear the pipeline before the registers may change.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sender. A byte is offered after a random number of idle cycles and held
  // until the block takes it; valid stays high into the next byte unless it idles first.
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] d, input logic l);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic stream_byte(input logic [7:0] d, input logic l);
    body_word_t w;
    push_byte(d, l);
    if (predict_word(d, l, w)) expected_words.push_back(w);
  endtask

  // A body built from chunks that exercise each filter rule: whitespace runs,
  // CR LF pairs, colon-slash pairs and broken ones, glyphs, entity bytes,
  // underscores, control and high bytes, repeats and plain noise. With close
  // low the body stays open and carries on into the next one, even across a phase.
  task automatic stream_random_body(input int len, input logic close, output int sent);
    logic [7:0] body[$];
    logic [7:0] c;
    int         reps;
    while (body.size() < len) begin
      case ($urandom_range(0, 11))
        0: body.push_back($urandom_range(0, 1) ? sbff_pkg::CH_SPACE
                          : 8'($urandom_range(sbff_pkg::CH_TAB, sbff_pkg::CH_CR)));
        1: begin
          body.push_back(sbff_pkg::CH_CR);
          body.push_back(sbff_pkg::CH_LF);
        end
        2: begin
          body.push_back(sbff_pkg::CH_COLON);
          body.push_back(sbff_pkg::CH_SLASH);
        end
        3: begin
          body.push_back(sbff_pkg::CH_COLON);
          body.push_back(8'($urandom_range(0, 255)));
        end
        4:  body.push_back(GLYPHS[$urandom_range(0, GLYPHS.len() - 1)]);
        5:  body.push_back(ENTITIES[$urandom_range(0, ENTITIES.len() - 1)]);
        6:  body.push_back($urandom_range(0, 1) ? sbff_pkg::CH_UNDER : sbff_pkg::CH_DOT);
        7:  body.push_back(8'($urandom_range(8'h30, 8'h7A)));
        8:  body.push_back($urandom_range(0, 3) == 0 ? sbff_pkg::CH_DEL
                                                     : 8'($urandom_range(0, 31)));
        9:  body.push_back(8'($urandom_range(128, 255)));
        10: body.push_back(8'($urandom_range(0, 255)));
        default: begin
          c    = (body.size() != 0) ? body[$] : 8'($urandom_range(0, 255));
          reps = $urandom_range(2, 4);
          repeat (reps) body.push_back(c);
        end
      endcase
    end
    foreach (body[i]) stream_byte(body[i], close && (i == body.size() - 1));
    sent = body.size();
  endtask

  // --------------------------------------------------------------------------
  // Receiver. Each word taken from the block is held against the oldest word
  // still owed; ready is redrawn every cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : receive_words
    body_word_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: out_byte %h, tlast %b, tuser %b", m_tdata, m_tlast,
                 m_tuser);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (m_tuser[0] !== want.byte_valid) begin
            $error("byte_valid: expected %b, got %b", want.byte_valid, m_tuser[0]);
            mismatches++;
          end
          if (m_tdata !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, m_tdata);
            mismatches++;
          end
          if (m_tlast !== want.end_of_body) begin
            $error("end_of_body: expected %b, got %b", want.end_of_body, m_tlast);
            mismatches++;
          end
          if (m_tuser[2:1] !== want.selected_filter) begin
            $error("selected_filter: expected %0d, got %0d", want.selected_filter,
                   m_tuser[2:1]);
            mismatches++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    body_word_t w;
    logic       produced;
    int         src_pct[3];
    int         sink_pct[3];
    int         stage_sent;
    int         phase_sent;
    int         sent;
    int         len;

    src_pct  = '{36, 67, 0};
    sink_pct = '{67, 36, 0};

    // Directed script, run at the reset settings to begin with.
    // Whitespace filter: graphic kept but not sent, space runs collapse,
    // LF after CR dropped (twice, since the kept byte stays CR), NUL sent.
    script.push_back(byte_row(ROW_SILENT, "A", 1'b0));
    script.push_back(typed_row(sbff_pkg::CH_SPACE, 1'b0, 1'b1, sbff_pkg::CH_SPACE, 1'b0,
                               sbff_pkg::FILTER_WHITESPACE));
    script.push_back(byte_row(ROW_SILENT, sbff_pkg::CH_SPACE, 1'b0));
    script.push_back(typed_row(sbff_pkg::CH_CR, 1'b0, 1'b1, sbff_pkg::CH_CR, 1'b0,
                               sbff_pkg::FILTER_WHITESPACE));
    script.push_back(byte_row(ROW_SILENT, sbff_pkg::CH_LF, 1'b0));
    script.push_back(byte_row(ROW_SILENT, sbff_pkg::CH_LF, 1'b0));
    script.push_back(typed_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0,
                               sbff_pkg::FILTER_WHITESPACE));
    script.push_back(byte_row(ROW_CHECKED, 8'hFF, 1'b1));
    // Punctuation filter: underscore turns into a dot and then collapses with
    // one, alphanumerics and entity bytes go, colon-slash counts.
    script.push_back(cfg_row(sbff_pkg::REG_FILTER_MODE,
                             sbff_pkg::CFG_DATA_WIDTH'(sbff_pkg::FILTER_PUNCT)));
    script.push_back(typed_row(sbff_pkg::CH_UNDER, 1'b0, 1'b1, sbff_pkg::CH_DOT, 1'b0,
                               sbff_pkg::FILTER_WHITESPACE));
    script.push_back(byte_row(ROW_SILENT, sbff_pkg::CH_DOT, 1'b0));
    script.push_back(byte_row(ROW_SILENT, "a", 1'b0));
    script.push_back(byte_row(ROW_SILENT, "%", 1'b0));
    script.push_back(byte_row(ROW_CHECKED, sbff_pkg::CH_COLON, 1'b0));
    script.push_back(byte_row(ROW_CHECKED, sbff_pkg::CH_SLASH, 1'b0));
    script.push_back(byte_row(ROW_CHECKED, 8'h80, 1'b1));
    // Graphic filter: equals sign dropped, a repeated glyph collapses.
    script.push_back(cfg_row(sbff_pkg::REG_FILTER_MODE,
                             sbff_pkg::CFG_DATA_WIDTH'(sbff_pkg::FILTER_GRAPHIC)));
    script.push_back(byte_row(ROW_SILENT, sbff_pkg::CH_EQUAL, 1'b0));
    script.push_back(byte_row(ROW_CHECKED, "!", 1'b0));
    script.push_back(byte_row(ROW_SILENT, "!", 1'b0));
    // Mode changes inside a body: a space kept by the punctuation filter is
    // still the kept byte once the whitespace filter takes over.
    script.push_back(cfg_row(sbff_pkg::REG_FILTER_MODE,
                             sbff_pkg::CFG_DATA_WIDTH'(sbff_pkg::FILTER_PUNCT)));
    script.push_back(byte_row(ROW_CHECKED, sbff_pkg::CH_SPACE, 1'b0));
    script.push_back(cfg_row(sbff_pkg::REG_FILTER_MODE,
                             sbff_pkg::CFG_DATA_WIDTH'(sbff_pkg::FILTER_WHITESPACE)));
    script.push_back(byte_row(ROW_SILENT, sbff_pkg::CH_SPACE, 1'b0));
    // An oversize mode value keeps its low bits only and selects no filter.
    // A write past the register list changes nothing. The body ends on a
    // colon that has no slash after it.
    script.push_back(cfg_row(sbff_pkg::REG_FILTER_MODE, ALL_ONES));
    script.push_back(byte_row(ROW_SILENT, sbff_pkg::CH_SPACE, 1'b0));
    script.push_back(cfg_row(REG_BEYOND, 16'h0001));
    script.push_back(byte_row(ROW_CHECKED, sbff_pkg::CH_COLON, 1'b1));
    // All thresholds at zero: the whitespace filter always qualifies.
    script.push_back(cfg_row(sbff_pkg::REG_FILTER_MODE,
                             sbff_pkg::CFG_DATA_WIDTH'(sbff_pkg::FILTER_GRAPHIC)));
    script.push_back(cfg_row(sbff_pkg::REG_MIN_LINE_FEEDS, '0));
    script.push_back(cfg_row(sbff_pkg::REG_MIN_BLANKS, '0));
    script.push_back(cfg_row(sbff_pkg::REG_MIN_DELIMITERS, '0));
    script.push_back(cfg_row(sbff_pkg::REG_MIN_LENGTH, '0));
    script.push_back(typed_row(sbff_pkg::CH_DEL, 1'b1, 1'b0, 8'h00, 1'b1,
                               sbff_pkg::FILTER_WHITESPACE));
    // All thresholds at their top: nothing qualifies.
    script.push_back(cfg_row(sbff_pkg::REG_MIN_LINE_FEEDS, ALL_ONES));
    script.push_back(cfg_row(sbff_pkg::REG_MIN_BLANKS, ALL_ONES));
    script.push_back(cfg_row(sbff_pkg::REG_MIN_DELIMITERS, ALL_ONES));
    script.push_back(cfg_row(sbff_pkg::REG_MIN_LENGTH, ALL_ONES));
    script.push_back(typed_row(8'h01, 1'b1, 1'b0, 8'h00, 1'b1, sbff_pkg::FILTER_NONE));

    src_idle_pct   = src_pct[0];
    sink_stall_pct = sink_pct[0];

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        settle();
        write_reg(script[i].reg_index, script[i].reg_value);
      end else begin
        push_byte(script[i].data, script[i].last);
        produced = predict_word(script[i].data, script[i].last, w);
        if (script[i].kind == ROW_TYPED) expected_words.push_back(script[i].word);
        else if ((script[i].kind == ROW_CHECKED) && produced) expected_words.push_back(w);
      end
    end

    // Random bodies in three idling stages, fresh register settings for each
    // phase. Now and then a body is left open across the settings change.
    for (int stage = 0; stage < 3; stage++) begin
      src_idle_pct   = src_pct[stage];
      sink_stall_pct = sink_pct[stage];
      stage_sent     = 0;
      while (stage_sent < STAGE_WORDS) begin
        settle();
        load_settings(($urandom_range(0, 4) == 0) ?
                        sbff_pkg::CFG_DATA_WIDTH'($urandom) :
                        sbff_pkg::CFG_DATA_WIDTH'($urandom_range(0, 3)),
                      pick_threshold(), pick_threshold(), pick_threshold(),
                      pick_threshold());
        if ($urandom_range(0, 3) == 0)
          write_reg(sbff_pkg::CFG_INDEX_WIDTH'($urandom_range(
                      int'(sbff_pkg::REG_MIN_LENGTH) + 1, int'(REG_BEYOND))),
                    sbff_pkg::CFG_DATA_WIDTH'($urandom));
        phase_sent = 0;
        while (phase_sent < PHASE_WORDS) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
          stream_random_body(len, $urandom_range(0, 4) != 0, sent);
          phase_sent += sent;
        end
        stage_sent += phase_sent;
      end
    end

    // Wait for the last owed word and let any stray byte drain.
    settle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sbff_pkg.sv
sv/spam_body_fingerprint_filter.sv
tb/spam_body_fingerprint_filter_test.sv
